// ===== hdl/sitoa_pkg.sv =====
// shared types, format codes and character helpers for the integer to text converter
package sitoa_pkg;

  localparam logic [1:0] ACT_DEC    = 2'd0;
  localparam logic [1:0] ACT_HEX_LO = 2'd1;
  localparam logic [1:0] ACT_HEX_UP = 2'd2;

  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         action;
  } sitoa_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
    logic [4:0] char_count;
  } sitoa_out_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic [1:0] act);
    logic [7:0] base;
    begin
      if (d < 4'd10) begin
        digit_char = CHAR_ZERO + {4'd0, d};
      end else begin
        base = (act == ACT_HEX_LO) ? CHAR_LOWER_A : CHAR_UPPER_A;
        digit_char = base + {4'd0, d} - 8'd10;
      end
    end
  endfunction

endpackage

// ===== hdl/sitoa_bcd_conv.sv =====
// iterative binary to bcd converter, one add-3 and shift step per cycle
module sitoa_bcd_conv #(
  parameter int VALUE_WIDTH = 64,
  parameter int NDIG        = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] bin,
  output logic                   done,
  output logic [NDIG*4-1:0]      bcd
);

  localparam int DIG_BITS = NDIG * 4;
  localparam int CW       = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [DIG_BITS-1:0]    bcd_r, bcd_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DIG_BITS-1:0]    adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = bin;
      bcd_nxt  = '0;
      cnt_nxt  = CW'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[DIG_BITS-2:0], bin_r[VALUE_WIDTH-1]};
      bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// ===== hdl/signed_int_to_ascii_base.sv =====
// top level: signed integer to ascii text, decimal or hexadecimal
//
// in channel: in_valid / in_ready / in_data carry one request, a signed value
// and a format code (decimal, lower-case hex, upper-case hex; code 3 as upper).
// out channel: out_valid / out_ready / out_data carry one character per
// transfer, most significant digit first, a leading minus for negative values;
// last marks the final character and char_count then holds the total.
// in_ready is high only while the sequencer is idle: one request at a time.
// decimal requests run VALUE_WIDTH add-3/shift steps in the bcd unit;
// hex requests skip that. leading zero digits are then dropped one per cycle,
// and each character passes through the output register. digits are kept
// as NDIG bcd or hex nibbles (NDIG = 20 for 64 bits); output stalls while
// out_ready is low, and a finished character waits in the output register
// while the next request can already be taken. synchronous active-low reset
// empties the output register and returns the sequencer to idle.
module signed_int_to_ascii_base
  import sitoa_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sitoa_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sitoa_out_t out_data
);

  localparam int ND_DEC   = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int ND_HEX   = (VALUE_WIDTH + 3) / 4;
  localparam int NDIG     = (ND_DEC > ND_HEX) ? ND_DEC : ND_HEX;
  localparam int DIG_BITS = NDIG * 4;
  localparam int RW       = $clog2(NDIG + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [DIG_BITS-1:0] dig_r, dig_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                neg_r, neg_nxt;
  logic [1:0]          act_r, act_nxt;
  logic                out_valid_r, out_valid_nxt;
  sitoa_out_t          out_data_r, out_data_nxt;

  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   conv_start;
  logic                   conv_done;
  logic [DIG_BITS-1:0]    conv_bcd;
  logic                   slot_free;
  logic [3:0]             top_dig;

  assign v         = in_data.value[VALUE_WIDTH-1:0];
  assign mag       = v[VALUE_WIDTH-1] ? (~v + VALUE_WIDTH'(1)) : v;
  assign slot_free = !out_valid_r || out_ready;
  assign top_dig   = dig_r[DIG_BITS-1 -: 4];
  assign in_ready  = (state_r == S_IDLE);
  assign conv_start = in_valid && in_ready && (in_data.action == ACT_DEC);

  sitoa_bcd_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .bin   (mag),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    act_nxt       = act_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt = v[VALUE_WIDTH-1];
          act_nxt = in_data.action;
          rem_nxt = RW'(NDIG);
          cnt_nxt = '0;
          if (in_data.action == ACT_DEC) begin
            state_nxt = S_CONV;
          end else begin
            dig_nxt   = DIG_BITS'(mag);
            state_nxt = S_SKIP;
          end
        end
      end
      S_CONV: begin
        if (conv_done) begin
          dig_nxt   = conv_bcd;
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_dig == 4'd0 && rem_r > RW'(1)) begin
          dig_nxt = {dig_r[DIG_BITS-5:0], 4'd0};
          rem_nxt = rem_r - RW'(1);
        end else begin
          state_nxt = neg_r ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.char_out   = CHAR_MINUS;
          out_data_nxt.last       = 1'b0;
          out_data_nxt.char_count = '0;
          cnt_nxt                 = 5'd1;
          state_nxt               = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.char_out   = digit_char(top_dig, act_r);
          out_data_nxt.last       = (rem_r == RW'(1));
          out_data_nxt.char_count = (rem_r == RW'(1)) ? (cnt_r + 5'd1) : 5'd0;
          cnt_nxt                 = cnt_r + 5'd1;
          dig_nxt                 = {dig_r[DIG_BITS-5:0], 4'd0};
          rem_nxt                 = rem_r - RW'(1);
          if (rem_r == RW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    act_r      <= act_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
